// ===== src/hvd_pkg.sv =====
// ----------------------------------------------------------------------------
// hvd_pkg
// Shared widths, fixed-point constants and the arctangent table for the
// haversine distance pipeline.
// ----------------------------------------------------------------------------
package hvd_pkg;

    // default number of cordic micro-rotations
    localparam int CORDIC_STAGES_DEF = 24;

    // field widths
    localparam int LAT_W    = 31;
    localparam int LON_W    = 32;
    localparam int RADIUS_W = 24;
    localparam int DIST_W   = 26;

    // internal widths
    localparam int ANG_W  = 36;   // signed q30 angle
    localparam int XY_W   = 34;   // signed cordic x/y
    localparam int ROOT_W = 31;   // square root in/out, 0..2^30
    localparam int REM_W  = 63;   // square root remainder
    localparam int Z_W    = 32;   // clamped central angle, unsigned

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 24'd6367000;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [XY_W-1:0]  GAIN_Q30    = 34'sd652032874;
    localparam logic [ROOT_W-1:0]       ONE_Q30     = 31'd1073741824;

    // atan(2^-i) in q30, truncated for i < 27 and rounded to nearest from i = 27
    localparam logic [31:0] ATAN_Q30 [0:31] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
        32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
    };

endpackage

// ===== src/hvd_cordic_rot.sv =====
// ----------------------------------------------------------------------------
// hvd_cordic_rot
// Pipelined rotation-mode cordic: range reduction, quadrant fold, then one
// micro-rotation per register stage. Gives sine and cosine in q30.
// ----------------------------------------------------------------------------
module hvd_cordic_rot #(
    parameter int STAGES = hvd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic signed [hvd_pkg::ANG_W-1:0] i_ang,
    output logic                            o_valid,
    output logic signed [hvd_pkg::XY_W-1:0]  o_sin,
    output logic signed [hvd_pkg::XY_W-1:0]  o_cos
);
    import hvd_pkg::*;

    logic signed [ANG_W-1:0] red;
    logic signed [ANG_W-1:0] fold;
    logic                    neg;

    logic signed [XY_W-1:0]  r_x   [0:STAGES];
    logic signed [XY_W-1:0]  r_y   [0:STAGES];
    logic signed [ANG_W-1:0] r_z   [0:STAGES];
    logic                    r_neg [0:STAGES];
    logic                    r_v   [0:STAGES];

    // reduce to [-pi, pi) and fold into [-pi/2, pi/2]
    always_comb begin
        red = i_ang;
        if (i_ang >= PI_Q30) begin
            red = i_ang - TWO_PI_Q30;
        end else if (i_ang < -PI_Q30) begin
            red = i_ang + TWO_PI_Q30;
        end
        fold = red;
        neg  = 1'b0;
        if (red > HALF_PI_Q30) begin
            fold = PI_Q30 - red;
            neg  = 1'b1;
        end else if (red < -HALF_PI_Q30) begin
            fold = -PI_Q30 - red;
            neg  = 1'b1;
        end
    end

    // entry stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_x[0]   <= GAIN_Q30;
        r_y[0]   <= '0;
        r_z[0]   <= fold;
        r_neg[0] <= neg;
    end

    // micro-rotations
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [ANG_W-1:0] atan_i;
        assign atan_i = $signed({{(ANG_W-32){1'b0}}, ATAN_Q30[i]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
            if (!r_z[i][ANG_W-1]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - atan_i;
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + atan_i;
            end
            r_neg[i+1] <= r_neg[i];
        end
    end

    assign o_valid = r_v[STAGES];
    assign o_sin   = r_y[STAGES];
    assign o_cos   = r_neg[STAGES] ? -r_x[STAGES] : r_x[STAGES];

endmodule

// ===== src/hvd_sqrt.sv =====
// ----------------------------------------------------------------------------
// hvd_sqrt
// Pipelined floor square root of a q30 value, one result bit per stage.
// The radicand is the input shifted left by 30, so the root is q30 again.
// ----------------------------------------------------------------------------
module hvd_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [hvd_pkg::ROOT_W-1:0]  i_op,
    output logic                        o_valid,
    output logic [hvd_pkg::ROOT_W-1:0]  o_root
);
    import hvd_pkg::*;

    logic [REM_W-1:0]  r_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] r_root [0:ROOT_W];
    logic              r_v    [0:ROOT_W];

    // entry stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_rem[0]  <= {2'b00, i_op, 30'd0};
        r_root[0] <= '0;
    end

    // one root bit per stage, msb first
    for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
        localparam int K = ROOT_W - 1 - j;
        logic [REM_W-1:0] trial;
        assign trial = (REM_W'(r_root[j]) << (K + 1)) + (REM_W'(1) << (2 * K));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else begin
                r_v[j+1] <= r_v[j];
            end
            if (r_rem[j] >= trial) begin
                r_rem[j+1]  <= r_rem[j] - trial;
                r_root[j+1] <= r_root[j] | (ROOT_W'(1) << K);
            end else begin
                r_rem[j+1]  <= r_rem[j];
                r_root[j+1] <= r_root[j];
            end
        end
    end

    assign o_valid = r_v[ROOT_W];
    assign o_root  = r_root[ROOT_W];

endmodule

// ===== src/hvd_cordic_vec.sv =====
// ----------------------------------------------------------------------------
// hvd_cordic_vec
// Pipelined vectoring-mode cordic giving atan2(y, x) in q30 radians for
// non-negative q30 inputs, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module hvd_cordic_vec #(
    parameter int STAGES = hvd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [hvd_pkg::ROOT_W-1:0]       i_y,
    input  logic [hvd_pkg::ROOT_W-1:0]       i_x,
    output logic                             o_valid,
    output logic signed [hvd_pkg::ANG_W-1:0] o_ang
);
    import hvd_pkg::*;

    logic signed [XY_W-1:0]  r_x [0:STAGES];
    logic signed [XY_W-1:0]  r_y [0:STAGES];
    logic signed [ANG_W-1:0] r_z [0:STAGES];
    logic                    r_v [0:STAGES];

    // entry stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_x[0] <= $signed({{(XY_W-ROOT_W){1'b0}}, i_x});
        r_y[0] <= $signed({{(XY_W-ROOT_W){1'b0}}, i_y});
        r_z[0] <= '0;
    end

    // micro-rotations driving y toward zero
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [ANG_W-1:0] atan_i;
        assign atan_i = $signed({{(ANG_W-32){1'b0}}, ATAN_Q30[i]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
            if (!r_y[i][XY_W-1]) begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + atan_i;
            end else begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - atan_i;
            end
        end
    end

    assign o_valid = r_v[STAGES];
    assign o_ang   = r_z[STAGES];

endmodule

// ===== src/haversine_distance_core.sv =====
// Throughput: one transaction per cycle; busy stays low, the pipeline never stalls.
// Latency is set by the two cordic pipelines and the 31-stage square root.
// Reset (synchronous, active low) clears all valid bits and sets the radius
// register to 6367000 m.
// ----------------------------------------------------------------------------
// haversine_distance_core
// Great-circle distance by the haversine formula, fully pipelined.
// ----------------------------------------------------------------------------
module haversine_distance_core #(
    parameter int CORDIC_STAGES = hvd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cfg_we,
    input  logic [hvd_pkg::RADIUS_W-1:0]        i_cfg_wdata,
    input  logic signed [hvd_pkg::LAT_W-1:0]    i_from_lat,
    input  logic signed [hvd_pkg::LON_W-1:0]    i_from_lon,
    input  logic signed [hvd_pkg::LAT_W-1:0]    i_to_lat,
    input  logic signed [hvd_pkg::LON_W-1:0]    i_to_lon,
    output logic                                o_valid,
    output logic [hvd_pkg::DIST_W-1:0]          o_distance_m
);
    import hvd_pkg::*;

    logic [RADIUS_W-1:0] r_radius;

    logic                    r_in_v;
    logic signed [LAT_W-1:0] r_lat1, r_lat2;
    logic signed [LON_W-1:0] r_lon1, r_lon2;

    logic signed [ANG_W-1:0] ang_dlat, ang_dlon, ang_lat1, ang_lat2;
    logic [3:0]              rot_v;
    logic signed [XY_W-1:0]  s_dlat, s_dlon, s_1, s_2;
    logic signed [XY_W-1:0]  c_dlat, c_dlon, c_1, c_2;

    logic signed [2*XY_W-1:0] prod_sq1, prod_sq2, prod_cc;
    logic                     r_m_v;
    logic signed [31:0]       r_sq1, r_sq2, r_cc;

    logic                     r_p_v;
    logic signed [63:0]       r_p;
    logic signed [31:0]       r_sq1_d;

    logic signed [34:0]       a_sum;
    logic                     r_a_v;
    logic [ROOT_W-1:0]        r_a;

    logic [1:0]               sq_v;
    logic [ROOT_W-1:0]        root_u, root_v;

    logic                     vec_v;
    logic signed [ANG_W-1:0]  vec_ang;
    logic signed [ANG_W-1:0]  ang2;

    logic                     r_z_v;
    logic [Z_W-1:0]           r_z;
    logic                     r_prod_v;
    logic [RADIUS_W+Z_W-1:0]  r_prod;
    logic [RADIUS_W+Z_W-1:0]  rounded;
    logic                     r_out_v;
    logic [DIST_W-1:0]        r_dist;

    // every cycle takes a transaction
    assign busy = 1'b0;

    // radius register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= start;
        end
        r_lat1 <= i_from_lat;
        r_lon1 <= i_from_lon;
        r_lat2 <= i_to_lat;
        r_lon2 <= i_to_lon;
    end

    // q29 differences read as q30 half angles, latitudes doubled to q30
    assign ang_dlat = ANG_W'(r_lat2) - ANG_W'(r_lat1);
    assign ang_dlon = ANG_W'(r_lon2) - ANG_W'(r_lon1);
    assign ang_lat1 = ANG_W'(r_lat1) <<< 1;
    assign ang_lat2 = ANG_W'(r_lat2) <<< 1;

    hvd_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_dlat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_in_v), .i_ang(ang_dlat),
        .o_valid(rot_v[0]), .o_sin(s_dlat), .o_cos(c_dlat)
    );
    hvd_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_dlon (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_in_v), .i_ang(ang_dlon),
        .o_valid(rot_v[1]), .o_sin(s_dlon), .o_cos(c_dlon)
    );
    hvd_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_lat1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_in_v), .i_ang(ang_lat1),
        .o_valid(rot_v[2]), .o_sin(s_1), .o_cos(c_1)
    );
    hvd_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_lat2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_in_v), .i_ang(ang_lat2),
        .o_valid(rot_v[3]), .o_sin(s_2), .o_cos(c_2)
    );

    // squares of the half-angle sines and the cosine product
    assign prod_sq1 = (2*XY_W)'(s_dlat) * (2*XY_W)'(s_dlat);
    assign prod_sq2 = (2*XY_W)'(s_dlon) * (2*XY_W)'(s_dlon);
    assign prod_cc  = (2*XY_W)'(c_1) * (2*XY_W)'(c_2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else begin
            r_m_v <= &rot_v;
        end
        r_sq1 <= 32'(prod_sq1 >>> 30);
        r_sq2 <= 32'(prod_sq2 >>> 30);
        r_cc  <= 32'(prod_cc >>> 30);
    end

    // cos1*cos2*sin^2(dlon/2)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else begin
            r_p_v <= r_m_v;
        end
        r_p     <= 64'(r_cc) * 64'(r_sq2);
        r_sq1_d <= r_sq1;
    end

    // sum and clamp a to [0, 1]
    assign a_sum = 35'(r_sq1_d) + 35'(r_p >>> 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= r_p_v;
        end
        if (a_sum[34]) begin
            r_a <= '0;
        end else if (a_sum > 35'(ONE_Q30)) begin
            r_a <= ONE_Q30;
        end else begin
            r_a <= ROOT_W'(a_sum);
        end
    end

    hvd_sqrt u_sqrt_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_a_v), .i_op(r_a),
        .o_valid(sq_v[0]), .o_root(root_u)
    );
    hvd_sqrt u_sqrt_1ma (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_a_v), .i_op(ONE_Q30 - r_a),
        .o_valid(sq_v[1]), .o_root(root_v)
    );

    hvd_cordic_vec #(.STAGES(CORDIC_STAGES)) u_atan2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(&sq_v), .i_y(root_u),
        .i_x(root_v), .o_valid(vec_v), .o_ang(vec_ang)
    );

    // central angle, clamped to [0, pi]
    assign ang2 = vec_ang <<< 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_v <= 1'b0;
        end else begin
            r_z_v <= vec_v;
        end
        if (ang2[ANG_W-1]) begin
            r_z <= '0;
        end else if (ang2 > PI_Q30) begin
            r_z <= Z_W'(PI_Q30);
        end else begin
            r_z <= Z_W'(ang2);
        end
    end

    // radius times angle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= r_z_v;
        end
        r_prod <= (RADIUS_W+Z_W)'(r_radius) * (RADIUS_W+Z_W)'(r_z);
    end

    // round to nearest metre
    assign rounded = r_prod + ((RADIUS_W+Z_W)'(1) << 29);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_prod_v;
        end
        r_dist <= rounded[30 +: DIST_W];
    end

    assign o_valid      = r_out_v;
    assign o_distance_m = r_dist;

endmodule

// ===== tb/tb_haversine_distance_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_haversine_distance_core
// Drives point pairs into the haversine distance pipeline, predicts each
// distance with an independent cordic/isqrt model and checks every result
// in order, across several sphere radius settings.
// ----------------------------------------------------------------------------
module tb_haversine_distance_core;
    import hvd_pkg::*;

    localparam int  STAGES     = CORDIC_STAGES_DEF;
    localparam int  LATENCY    = 2 * STAGES + 41;
    localparam longint LAT_MAX = 843314857;
    localparam longint LON_MAX = 1686629713;
    localparam longint ONE     = 64'd1073741824;
    localparam longint HPI     = 64'd1686629713;
    localparam longint PI      = 64'd3373259426;
    localparam longint TWO_PI  = 64'd6746518852;
    localparam longint GAIN    = 64'd652032874;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic                       i_cfg_we;
    logic [RADIUS_W-1:0]        i_cfg_wdata;
    logic signed [LAT_W-1:0]    i_from_lat;
    logic signed [LON_W-1:0]    i_from_lon;
    logic signed [LAT_W-1:0]    i_to_lat;
    logic signed [LON_W-1:0]    i_to_lon;
    logic                       o_valid;
    logic [DIST_W-1:0]          o_distance_m;

    logic [RADIUS_W-1:0]        radius_m;
    logic [DIST_W-1:0]          distance_q[$];
    int                         send_idle_pct;
    bit                         failed;

    haversine_distance_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_from_lat  (i_from_lat),
        .i_from_lon  (i_from_lon),
        .i_to_lat    (i_to_lat),
        .i_to_lon    (i_to_lon),
        .o_valid     (o_valid),
        .o_distance_m(o_distance_m)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

    // arithmetic shift with floor rounding
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    // rotation-mode cordic: sine and cosine of a q30 angle
    function automatic void cordic_sin_cos(input longint ang, output longint s,
                                           output longint c);
        longint r, x, y, z, dx, dy;
        bit     neg;
        r = ang % TWO_PI;
        neg = 1'b0;
        if (r >= PI) r -= TWO_PI;
        else if (r < -PI) r += TWO_PI;
        if (r > HPI) begin
            r = PI - r;
            neg = 1'b1;
        end else if (r < -HPI) begin
            r = -PI - r;
            neg = 1'b1;
        end
        x = GAIN;
        y = 0;
        z = r;
        for (int i = 0; i < STAGES; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
            end
        end
        s = y;
        c = neg ? -x : x;
    endfunction

    // exact floor square root
    function automatic longint floor_sqrt(longint unsigned op);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > op) b >>= 2;
        while (b != 0) begin
            if (op >= res + b) begin
                op -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    // vectoring-mode cordic for first-quadrant atan2
    function automatic longint cordic_atan2(longint yv, longint xv);
        longint x, y, z, dx, dy;
        x = xv; y = yv; z = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
            end
        end
        return z;
    endfunction

    // expected great-circle distance in metres
    function automatic logic [DIST_W-1:0] great_circle_m(longint lat1, longint lon1,
                                                          longint lat2, longint lon2);
        longint sdl, cdl, sdo, cdo, s1, c1, s2, c2, hav, u, v, z;
        longint unsigned d;
        cordic_sin_cos(lat2 - lat1, sdl, cdl);
        cordic_sin_cos(lon2 - lon1, sdo, cdo);
        cordic_sin_cos(lat1 * 2, s1, c1);
        cordic_sin_cos(lat2 * 2, s2, c2);
        hav = floor_shr(sdl * sdl, 30)
            + floor_shr(floor_shr(c1 * c2, 30) * floor_shr(sdo * sdo, 30), 30);
        if (hav < 0) hav = 0;
        if (hav > ONE) hav = ONE;
        u = floor_sqrt(longint'(hav) << 30);
        v = floor_sqrt(longint'(ONE - hav) << 30);
        z = 2 * cordic_atan2(u, v);
        if (z < 0) z = 0;
        if (z > PI) z = PI;
        d = (longint'(radius_m) * z + (64'd1 << 29)) >> 30;
        return d[DIST_W-1:0];
    endfunction

    // send one transaction, with random idle cycles ahead of it
    task automatic send_pair(longint lat1, longint lon1, longint lat2, longint lon2);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_from_lat <= lat1[LAT_W-1:0];
        i_from_lon <= lon1[LON_W-1:0];
        i_to_lat   <= lat2[LAT_W-1:0];
        i_to_lon   <= lon2[LON_W-1:0];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        distance_q.push_back(great_circle_m(lat1, lon1, lat2, lon2));
    endtask

    // stop sending and wait until the pipeline has drained
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (distance_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY / 4) @(posedge i_clk);
    endtask

    task automatic write_radius(logic [RADIUS_W-1:0] r);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= r;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        radius_m     = r;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (distance_q.size() == 0) begin
                $error("distance_m: unexpected result %0d", o_distance_m);
                failed = 1'b1;
            end else begin
                if (o_distance_m !== distance_q[0]) begin
                    $error("distance_m: expected %0d actual %0d",
                           distance_q[0], o_distance_m);
                    failed = 1'b1;
                end
                void'(distance_q.pop_front());
            end
        end
    end

    function automatic longint rand_span(longint lim);
        return longint'($urandom_range(2 * lim, 0)) - lim;
    endfunction

    function automatic longint rand_word(int w);
        longint r;
        r = {$urandom(), $urandom()};
        r = r & ((64'd1 << w) - 1);
        return (r ^ (64'd1 << (w - 1))) - (64'd1 << (w - 1));
    endfunction

    // field extremes, poles, antipodes and the longitude wrap
    task automatic test_directed();
        send_pair(0, 0, 0, 0);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0);
        send_pair(0, -LON_MAX, 0, LON_MAX);
        send_pair(0, 0, 0, LON_MAX);
        send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
        send_pair(-LAT_MAX, -LON_MAX, -LAT_MAX, LON_MAX);
        send_pair(LAT_MAX, 0, LAT_MAX, LON_MAX);
        send_pair(100, 200, 100, 201);
        send_pair(-5000, 7000, 3000, -2000);
        // angles outside the nominal range, including full-scale words
        send_pair(-(64'sd1 << 30), -(64'sd1 << 31), (64'sd1 << 30) - 1, (64'sd1 << 31) - 1);
        send_pair((64'sd1 << 30) - 1, 0, (64'sd1 << 30) - 1, -(64'sd1 << 31));
        send_pair(-(64'sd1 << 30), (64'sd1 << 31) - 1, 0, 0);
        send_pair(-1, -1, -1, -1);
        send_pair(LAT_MAX / 2, LON_MAX / 3, -LAT_MAX / 4, -LON_MAX / 5);
    endtask

    // random pairs; most within range, a share near each other, some raw words
    task automatic test_random(int n);
        longint lat1, lon1, lat2, lon2;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3, 0))
                0: begin
                    lat1 = rand_word(LAT_W); lon1 = rand_word(LON_W);
                    lat2 = rand_word(LAT_W); lon2 = rand_word(LON_W);
                end
                1: begin
                    lat1 = rand_span(LAT_MAX); lon1 = rand_span(LON_MAX);
                    lat2 = lat1 + rand_span(1 << $urandom_range(20, 0));
                    lon2 = lon1 + rand_span(1 << $urandom_range(20, 0));
                    if (lat2 > LAT_MAX || lat2 < -LAT_MAX) lat2 = lat1;
                    if (lon2 > LON_MAX || lon2 < -LON_MAX) lon2 = lon1;
                end
                default: begin
                    lat1 = rand_span(LAT_MAX); lon1 = rand_span(LON_MAX);
                    lat2 = rand_span(LAT_MAX); lon2 = rand_span(LON_MAX);
                end
            endcase
            send_pair(lat1, lon1, lat2, lon2);
        end
    endtask

    initial begin
        failed        = 1'b0;
        radius_m      = RADIUS_RST;
        send_idle_pct = 33;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_from_lat    = '0;
        i_from_lon    = '0;
        i_to_lat      = '0;
        i_to_lon      = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset radius
        test_directed();
        test_random(400);
        drain();

        // largest radius
        write_radius({RADIUS_W{1'b1}});
        send_idle_pct = 50;
        test_directed();
        test_random(400);
        drain();

        // smallest nonzero radius
        write_radius(1);
        send_idle_pct = 0;
        test_directed();
        test_random(200);
        drain();

        // a random radius, then 6371000 m, no idling
        write_radius(RADIUS_W'($urandom_range(16777215, 1)));
        test_random(350);
        drain();
        write_radius(6371000);
        test_random(350);
        drain();

        repeat (LATENCY + 10) @(posedge i_clk);
        if (!failed && distance_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            if (distance_q.size() != 0)
                $error("distance_m: %0d results never arrived", distance_q.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
